FILE: rtl/pli_pkg.sv
package pli_pkg;

   localparam int DEPTH   = 64;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int POS_W   = 7;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 7;
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_ILLEGAL = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DELETE,
      OP_ROTATE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                emit;
      logic [STAT_W-1:0]   status;
      logic                last;
      logic                show_entry;
   } dp_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0]    count;
      logic                full;
      logic                ins_pos_ok;
      logic                del_pos_ok;
   } dp_stat_type;

endpackage

FILE: rtl/pli_datapath.sv
module pli_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pli_pkg::dp_ctrl_type                 ctrl,
   output pli_pkg::dp_stat_type                 stat,
   input  logic [pli_pkg::POS_W-1:0]            req_position,
   input  logic signed [pli_pkg::WORD_W-1:0]    req_value,
   output logic                                 rsp_valid,
   output logic [pli_pkg::STAT_W-1:0]           rsp_status,
   output logic signed [pli_pkg::WORD_W-1:0]    rsp_entry,
   output logic [pli_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_last
);

   logic signed [pli_pkg::WORD_W-1:0] entries_ff [pli_pkg::DEPTH];
   logic signed [pli_pkg::WORD_W-1:0] entries_in [pli_pkg::DEPTH];
   logic [pli_pkg::CNT_W-1:0]         count_ff;
   logic [pli_pkg::CNT_W-1:0]         count_in;

   logic                              rsp_valid_ff;
   logic [pli_pkg::STAT_W-1:0]        rsp_status_ff;
   logic signed [pli_pkg::WORD_W-1:0] rsp_entry_ff;
   logic [pli_pkg::CNT_W-1:0]         rsp_count_ff;
   logic                              rsp_last_ff;

   logic [pli_pkg::CMP_W-1:0] pos_ext;
   logic [pli_pkg::CMP_W-1:0] pos0;
   logic [pli_pkg::CMP_W-1:0] cnt_ext;
   logic [pli_pkg::CMP_W-1:0] cnt_m1;

   assign pos_ext = pli_pkg::CMP_W'(req_position);
   assign pos0    = pos_ext - pli_pkg::CMP_W'(1);
   assign cnt_ext = pli_pkg::CMP_W'(count_ff);
   assign cnt_m1  = cnt_ext - pli_pkg::CMP_W'(1);

   assign stat.count      = count_ff;
   assign stat.full       = (count_ff == pli_pkg::CNT_W'(pli_pkg::DEPTH));
   assign stat.ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + pli_pkg::CMP_W'(1));
   assign stat.del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);

   // One cell per entry; each cell picks a neighbor, the new word, the head word or holds.
   for (genvar gi = 0; gi < pli_pkg::DEPTH; gi++) begin : g_cell
      localparam logic [pli_pkg::CMP_W-1:0] IDX = pli_pkg::CMP_W'(gi);
      logic signed [pli_pkg::WORD_W-1:0] below;
      logic signed [pli_pkg::WORD_W-1:0] above;

      if (gi == 0) begin : g_first
         assign below = entries_ff[0];
      end else begin : g_below
         assign below = entries_ff[gi-1];
      end

      if (gi == pli_pkg::DEPTH - 1) begin : g_top
         assign above = entries_ff[gi];
      end else begin : g_above
         assign above = entries_ff[gi+1];
      end

      always_comb begin
         entries_in[gi] = entries_ff[gi];
         case (ctrl.op)
            pli_pkg::OP_INSERT: begin
               if (IDX > pos0) begin
                  entries_in[gi] = below;
               end else if (IDX == pos0) begin
                  entries_in[gi] = req_value;
               end
            end
            pli_pkg::OP_DELETE: begin
               if (IDX >= pos0) begin
                  entries_in[gi] = above;
               end
            end
            pli_pkg::OP_ROTATE: begin
               // move head to the tail so the list is whole after a full pass
               if (IDX < cnt_m1) begin
                  entries_in[gi] = above;
               end else if (IDX == cnt_m1) begin
                  entries_in[gi] = entries_ff[0];
               end
            end
            default: begin
               entries_in[gi] = entries_ff[gi];
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      case (ctrl.op)
         pli_pkg::OP_INSERT: count_in = count_ff + pli_pkg::CNT_W'(1);
         pli_pkg::OP_DELETE: count_in = count_ff - pli_pkg::CNT_W'(1);
         default:            count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_status_ff <= ctrl.status;
         rsp_entry_ff  <= ctrl.show_entry ? entries_ff[0] : '0;
         rsp_count_ff  <= count_in;
         rsp_last_ff   <= ctrl.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_entry    = rsp_entry_ff;
   assign rsp_count    = pli_pkg::COUNT_W'(rsp_count_ff);
   assign rsp_is_empty = (rsp_count_ff == '0);
   assign rsp_last     = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pli_pkg::CNT_W'(pli_pkg::DEPTH))
      else $error("count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == pli_pkg::OP_INSERT |=> count_ff == $past(count_ff) + pli_pkg::CNT_W'(1))
      else $error("insert did not grow the list");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == pli_pkg::OP_DELETE |=> count_ff == $past(count_ff) - pli_pkg::CNT_W'(1))
      else $error("delete did not shrink the list");

   a_rotate_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == pli_pkg::OP_ROTATE |-> count_ff != '0 && ctrl.emit && ctrl.show_entry)
      else $error("rotate on empty list or without a result");

endmodule

FILE: rtl/pli_control.sv
module pli_control (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [pli_pkg::CMD_W-1:0]   req_cmd,
   input  pli_pkg::dp_stat_type        stat,
   output pli_pkg::dp_ctrl_type        ctrl
);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   logic [pli_pkg::CNT_W-1:0] rem_ff;
   logic [pli_pkg::CNT_W-1:0] rem_in;

   assign busy = (state_ff == S_DUMP);

   always_comb begin
      state_in        = state_ff;
      rem_in          = rem_ff;
      ctrl.op         = pli_pkg::OP_HOLD;
      ctrl.emit       = 1'b0;
      ctrl.status     = pli_pkg::ST_OK;
      ctrl.last       = 1'b1;
      ctrl.show_entry = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.emit = 1'b1;
               unique case (req_cmd)
                  pli_pkg::CMD_INSERT: begin
                     if (stat.full) begin
                        ctrl.status = pli_pkg::ST_FULL;
                     end else if (stat.ins_pos_ok) begin
                        ctrl.op = pli_pkg::OP_INSERT;
                     end else begin
                        ctrl.status = pli_pkg::ST_ILLEGAL;
                     end
                  end
                  pli_pkg::CMD_DELETE: begin
                     if (stat.del_pos_ok) begin
                        ctrl.op = pli_pkg::OP_DELETE;
                     end else begin
                        ctrl.status = pli_pkg::ST_ILLEGAL;
                     end
                  end
                  pli_pkg::CMD_DUMP: begin
                     if (stat.count == '0) begin
                        ctrl.status = pli_pkg::ST_EMPTY;
                     end else begin
                        // entries go out from the dump state, one per cycle
                        ctrl.emit = 1'b0;
                        state_in  = S_DUMP;
                        rem_in    = stat.count;
                     end
                  end
                  default: begin
                     ctrl.status = pli_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_DUMP: begin
            ctrl.op         = pli_pkg::OP_ROTATE;
            ctrl.emit       = 1'b1;
            ctrl.show_entry = 1'b1;
            ctrl.last       = (rem_ff == pli_pkg::CNT_W'(1));
            rem_in          = rem_ff - pli_pkg::CNT_W'(1);
            if (ctrl.last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
      end
   end

   a_dump_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> rem_ff != '0 && rem_ff <= stat.count)
      else $error("dump countdown out of range");

   a_dump_ends_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP && rem_ff == pli_pkg::CNT_W'(1) |=> state_ff == S_IDLE)
      else $error("dump did not finish on last entry");

endmodule

FILE: rtl/positional_insert_delete_list.sv
// Channel   Handshake          Ports
// input     start & !busy      req_cmd, req_position, req_value
// result    rsp_valid (1 clk)  rsp_status, rsp_entry, rsp_count, rsp_is_empty, rsp_last
//
// Insert, delete, an unused code and a dump of an empty list give their result in the
// cycle after acceptance, and busy stays low.
// A dump of n entries holds busy while the entries go out, one entry per cycle, by
// rotating the chain of entry cells through its head; after n steps the order is restored.
// Synchronous reset clears the count, the controller and the result strobe; the entry
// cells are not cleared. Results cannot be stalled.
module positional_insert_delete_list (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pli_pkg::CMD_W-1:0]            req_cmd,
   input  logic [pli_pkg::POS_W-1:0]            req_position,
   input  logic signed [pli_pkg::WORD_W-1:0]    req_value,
   output logic                                 rsp_valid,
   output logic [pli_pkg::STAT_W-1:0]           rsp_status,
   output logic signed [pli_pkg::WORD_W-1:0]    rsp_entry,
   output logic [pli_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_last
);

   pli_pkg::dp_ctrl_type ctrl;
   pli_pkg::dp_stat_type stat;

   pli_control u_control (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .req_cmd (req_cmd),
      .stat    (stat),
      .ctrl    (ctrl)
   );

   pli_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .stat         (stat),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_entry    (rsp_entry),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .rsp_last     (rsp_last)
   );

endmodule
